// ----- rtl/sjlsq_pkg.sv -----
`timescale 1ns / 1ps

package sjlsq_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_SERVE   = 2'd1;
  localparam logic [1:0] OP_DRAIN   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Status codes of a result item
  localparam logic [1:0] STATUS_ENQUEUED = 2'd0;
  localparam logic [1:0] STATUS_SERVED   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam int TAG_W     = 16;
  localparam int AMOUNT_W  = 32;
  localparam int REVENUE_W = 48;

  localparam logic [REVENUE_W-1:0] REVENUE_MAX = '1;

  typedef struct packed {
    logic [1:0]          operation;
    logic [TAG_W-1:0]    item_tag;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [1:0]           queue_index;
    logic [TAG_W-1:0]     out_tag;
    logic [AMOUNT_W-1:0]  out_amount;
    logic [REVENUE_W-1:0] revenue_total;
    logic                 last;
  } out_item_t;

  // Command handed from the front to the back
  typedef struct packed {
    logic [1:0]          op;
    logic [TAG_W-1:0]    tag;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

endpackage

// ----- rtl/sjlsq_front.sv -----
`timescale 1ns / 1ps

module sjlsq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sjlsq_pkg::in_item_t in_item,
  output logic                cmd_valid,
  output sjlsq_pkg::cmd_t     cmd,
  input  logic                cmd_pop
);
  import sjlsq_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];

  // Drop the unused operation code at the door: it has no effect at all
  assign push = in_valid && !in_stall && (in_item.operation != OP_UNUSED);
  assign pop  = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{op: in_item.operation, tag: in_item.item_tag,
                            amount: in_item.amount};
    end
  end

endmodule

// ----- rtl/sjlsq_back.sv -----
`timescale 1ns / 1ps

module sjlsq_back #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  sjlsq_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sjlsq_pkg::out_item_t out_item
);
  import sjlsq_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
  localparam int AW = QW + HW;
  localparam int P  = 1 << QW;
  localparam int NODES = 2 * P - 1;

  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [HW:0]   DEPTH_W = (HW + 1)'(QUEUE_DEPTH);
  localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

  localparam logic [1:0] S_IDLE       = 2'd0;
  localparam logic [1:0] S_SERVE_RD   = 2'd1;
  localparam logic [1:0] S_DRAIN_SCAN = 2'd2;
  localparam logic [1:0] S_DRAIN_RD   = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [AMOUNT_W-1:0] amount;
  } entry_t;

  function automatic logic [1:0] qidx(input logic [QW-1:0] q);
    logic [QW+1:0] w;
    w = (QW + 2)'(q);
    return w[1:0];
  endfunction

  // Queue memory, one row of slots per queue
  entry_t mem [1 << AW];
  entry_t rd_data_r;

  logic [CW-1:0] counts_r [NUM_QUEUES];
  logic [CW-1:0] counts_nxt [NUM_QUEUES];
  logic [HW-1:0] heads_r [NUM_QUEUES];
  logic [HW-1:0] heads_nxt [NUM_QUEUES];
  logic [TW-1:0] total_r, total_nxt;
  logic [REVENUE_W-1:0] revenue_r, revenue_nxt;
  logic [1:0]    state_r, state_nxt;
  logic [QW-1:0] sel_q_r, sel_q_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;
  logic          emit;
  out_item_t     emit_item;
  logic          out_free;
  logic          pop_en;
  logic [QW-1:0] pop_q;
  logic [REVENUE_W:0]   rev_sum;
  logic [REVENUE_W-1:0] rev_sat;
  logic [HW:0]   tail_sum;
  logic [HW-1:0] tail_slot;

  // Tournament trees for shortest and longest queue; the left side wins ties
  logic [CW-1:0] min_v [NODES];
  logic [QW-1:0] min_i [NODES];
  logic [CW-1:0] max_v [NODES];
  logic [QW-1:0] max_i [NODES];

  always_comb begin
    for (int j = 0; j < P; j++) begin
      min_i[P - 1 + j] = QW'(j);
      max_i[P - 1 + j] = QW'(j);
      if (j < NUM_QUEUES) begin
        min_v[P - 1 + j] = counts_r[j];
        max_v[P - 1 + j] = counts_r[j];
      end else begin
        min_v[P - 1 + j] = '1;
        max_v[P - 1 + j] = '0;
      end
    end
    for (int i = P - 2; i >= 0; i--) begin
      if (min_v[2 * i + 2] < min_v[2 * i + 1]) begin
        min_v[i] = min_v[2 * i + 2];
        min_i[i] = min_i[2 * i + 2];
      end else begin
        min_v[i] = min_v[2 * i + 1];
        min_i[i] = min_i[2 * i + 1];
      end
      if (max_v[2 * i + 2] > max_v[2 * i + 1]) begin
        max_v[i] = max_v[2 * i + 2];
        max_i[i] = max_i[2 * i + 2];
      end else begin
        max_v[i] = max_v[2 * i + 1];
        max_i[i] = max_i[2 * i + 1];
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign rev_sum = {1'b0, revenue_r} + (REVENUE_W + 1)'(rd_data_r.amount);
  assign rev_sat = rev_sum[REVENUE_W] ? REVENUE_MAX : rev_sum[REVENUE_W-1:0];

  // Tail slot of the shortest queue, wrapped once into the row
  assign tail_sum  = {1'b0, heads_r[min_i[0]]} + (HW + 1)'(min_v[0]);
  assign tail_slot = (tail_sum >= DEPTH_W) ? HW'(tail_sum - DEPTH_W) : tail_sum[HW-1:0];

  always_comb begin
    counts_nxt    = counts_r;
    heads_nxt     = heads_r;
    total_nxt     = total_r;
    revenue_nxt   = revenue_r;
    state_nxt     = state_r;
    sel_q_nxt     = sel_q_r;
    cmd_pop       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    emit          = 1'b0;
    emit_item     = '0;
    pop_en        = 1'b0;
    pop_q         = sel_q_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          emit_item.revenue_total = revenue_r;
          emit_item.last          = 1'b1;
          case (cmd.op)
            OP_ENQUEUE: begin
              emit = 1'b1;
              emit_item.queue_index = qidx(min_i[0]);
              if (min_v[0] >= DEPTH_C) begin
                emit_item.status = STATUS_FULL;
              end else begin
                emit_item.status = STATUS_ENQUEUED;
                wr_en   = 1'b1;
                wr_addr = {min_i[0], tail_slot};
                wr_data = '{tag: cmd.tag, amount: cmd.amount};
                counts_nxt[min_i[0]] = min_v[0] + CW'(1);
                total_nxt = total_r + TW'(1);
              end
            end
            OP_SERVE: begin
              if (max_v[0] == '0) begin
                emit = 1'b1;
                emit_item.status = STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = {max_i[0], heads_r[max_i[0]]};
                sel_q_nxt = max_i[0];
                state_nxt = S_SERVE_RD;
              end
            end
            default: begin
              if (total_r == '0) begin
                emit = 1'b1;
                emit_item.status = STATUS_EMPTY;
              end else begin
                sel_q_nxt = '0;
                state_nxt = S_DRAIN_SCAN;
              end
            end
          endcase
        end
      end
      S_SERVE_RD: begin
        if (out_free) begin
          pop_en    = 1'b1;
          emit      = 1'b1;
          emit_item = '{status: STATUS_SERVED, queue_index: qidx(sel_q_r),
                        out_tag: rd_data_r.tag, out_amount: rd_data_r.amount,
                        revenue_total: rev_sat, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN_SCAN: begin
        // skip empty queues; some item remains, so one is found
        if (counts_r[sel_q_r] == '0) begin
          sel_q_nxt = sel_q_r + QW'(1);
        end else begin
          rd_en     = 1'b1;
          rd_addr   = {sel_q_r, heads_r[sel_q_r]};
          state_nxt = S_DRAIN_RD;
        end
      end
      default: begin
        if (out_free) begin
          pop_en    = 1'b1;
          emit      = 1'b1;
          emit_item = '{status: STATUS_SERVED, queue_index: qidx(sel_q_r),
                        out_tag: rd_data_r.tag, out_amount: rd_data_r.amount,
                        revenue_total: rev_sat, last: (total_r == TW'(1))};
          if (total_r == TW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DRAIN_SCAN;
          end
        end
      end
    endcase

    if (pop_en) begin
      counts_nxt[pop_q] = counts_r[pop_q] - CW'(1);
      heads_nxt[pop_q]  = (heads_r[pop_q] == HEAD_LAST) ? '0 : heads_r[pop_q] + HW'(1);
      total_nxt         = total_r - TW'(1);
      revenue_nxt       = rev_sat;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        counts_r[q] <= '0;
        heads_r[q]  <= '0;
      end
      total_r     <= '0;
      revenue_r   <= '0;
      state_r     <= S_IDLE;
      sel_q_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      counts_r    <= counts_nxt;
      heads_r     <= heads_nxt;
      total_r     <= total_nxt;
      revenue_r   <= revenue_nxt;
      state_r     <= state_nxt;
      sel_q_r     <= sel_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/shortest_join_longest_serve_queues_unit.sv -----
`timescale 1ns / 1ps

// Channel  Ports                              Transfer when
// input    in_valid, in_stall, in_item        in_valid && !in_stall
// result   out_valid, out_stall, out_item     out_valid && !out_stall
//
// A transfer is registered in the command queue and reaches the back end
// from there. Enqueue completes in the back end's IDLE state; serve goes on
// to SERVE_RD, as the queue memory's read port is registered. Drain starts
// in IDLE, then per item passes DRAIN_SCAN, stepping past empty queues, and
// DRAIN_RD; a drain of an empty bank ends in IDLE. Reset (rst_n low,
// synchronous) empties every queue and clears revenue; the queue memory
// itself is never cleared. in_stall rises when the two-entry command queue
// is full; out_stall holds the result register and, behind it, the back end.

module shortest_join_longest_serve_queues_unit #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sjlsq_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sjlsq_pkg::out_item_t out_item
);
  import sjlsq_pkg::*;

  // Command path between front and back
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Front: accept the transfer, drop the unused code, buffer the command
  sjlsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back: pick the queue, access the memory, advance revenue, hold the result
  sjlsq_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
